// File: hw/rtl/cfp_pkg.sv
// Shared types and constants for the centerline frame propagation block.
// Used by cfp_norm, cfp_cross and centerline_frame_propagation_top; no dependencies.

package cfp_pkg;

   localparam int UNIT_FRAC_BITS = 14;
   localparam int UNIT_W         = 16;
   localparam int POS_W          = 32;
   localparam int WIDE_W         = 33;
   localparam int NUM_W          = 31 + UNIT_FRAC_BITS;
   localparam int STEP_W         = $clog2(UNIT_FRAC_BITS + 1);

   localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC_BITS);

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FALLBACK = 2'd1;
   localparam logic [1:0] STAT_ZERO     = 2'd2;
   localparam logic [1:0] STAT_SHORT    = 2'd3;

   typedef logic [2:0][POS_W-1:0]  pos_vec_type;
   typedef logic [2:0][WIDE_W-1:0] wide_vec_type;
   typedef logic [2:0][UNIT_W-1:0] unit_vec_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               end_of_line;
   } req_type;

   typedef struct packed {
      logic        [15:0] frame_index;
      logic signed [15:0] axis_x_0;
      logic signed [15:0] axis_x_1;
      logic signed [15:0] axis_x_2;
      logic signed [15:0] axis_y_0;
      logic signed [15:0] axis_y_1;
      logic signed [15:0] axis_y_2;
      logic signed [15:0] tan_0;
      logic signed [15:0] tan_1;
      logic signed [15:0] tan_2;
      logic        [1:0]  status;
      logic               final_frame;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic nonzero;
   } norm_stat_type;

endpackage

// File: hw/rtl/cfp_norm.sv
// Iterative vector normalizer: scale, sum of squares, bit-serial square root, restoring divide.
// Depends on cfp_pkg.

module cfp_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cfp_pkg::wide_vec_type vec_in,
   output cfp_pkg::norm_stat_type stat,
   output cfp_pkg::unit_vec_type unit_out
);

   typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV} state_type;

   state_type                          state_ff;
   logic [2:0][cfp_pkg::WIDE_W-1:0]    mag_ff;
   logic [2:0]                         neg_ff;
   logic [1:0]                         idx_ff;
   logic [61:0]                        acc_ff;
   logic [61:0]                        res_ff;
   logic [60:0]                        bit_ff;
   logic [cfp_pkg::NUM_W-1:0]          rem_ff;
   logic [cfp_pkg::NUM_W-1:0]          den_ff;
   logic [cfp_pkg::UNIT_FRAC_BITS:0]   q_ff;
   logic [cfp_pkg::STEP_W-1:0]         step_ff;
   logic                               done_ff;
   logic                               nz_ff;
   cfp_pkg::unit_vec_type              unit_ff;

   logic [cfp_pkg::WIDE_W-1:0]         mx;
   logic [29:0]                        msel;
   logic [59:0]                        sq;
   logic [61:0]                        trial;
   logic                               q_bit;
   logic [cfp_pkg::UNIT_FRAC_BITS:0]   q_in;
   logic [cfp_pkg::UNIT_W-1:0]         q_ext;

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) begin
         mx = mag_ff[1];
      end
      if (mag_ff[2] > mx) begin
         mx = mag_ff[2];
      end
   end

   assign msel  = mag_ff[idx_ff][29:0];
   assign sq    = msel * msel;
   assign trial = res_ff + 62'(bit_ff);
   assign q_bit = (rem_ff >= den_ff);
   assign q_in  = {q_ff[cfp_pkg::UNIT_FRAC_BITS-1:0], q_bit};
   assign q_ext = cfp_pkg::UNIT_W'(q_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         nz_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vec_in[i][cfp_pkg::WIDE_W-1];
                     mag_ff[i] <= vec_in[i][cfp_pkg::WIDE_W-1] ?
                                  cfp_pkg::WIDE_W'(0) - vec_in[i] : vec_in[i];
                  end
                  state_ff <= N_SHIFT;
               end
            end
            N_SHIFT: begin
               priority if (mx == '0) begin
                  unit_ff  <= '0;
                  nz_ff    <= 1'b0;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (mx[32:30] != 3'd0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (mx[29:25] == 5'd0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 4;
               end else if (!mx[29]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  acc_ff   <= '0;
                  idx_ff   <= 2'd0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               acc_ff <= acc_ff + 62'(sq);
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  res_ff   <= '0;
                  bit_ff   <= {1'b1, 60'd0};
                  state_ff <= N_SQRT;
               end
            end
            N_SQRT: begin
               if (acc_ff >= trial) begin
                  acc_ff <= acc_ff - trial;
                  res_ff <= (res_ff >> 1) + 62'(bit_ff);
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  idx_ff   <= 2'd0;
                  state_ff <= N_DSET;
               end
            end
            N_DSET: begin
               rem_ff   <= {cfp_pkg::NUM_W'(msel) << cfp_pkg::UNIT_FRAC_BITS}
                           + cfp_pkg::NUM_W'(res_ff[30:1]);
               den_ff   <= cfp_pkg::NUM_W'(res_ff[30:0]) << cfp_pkg::UNIT_FRAC_BITS;
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (q_bit) begin
                  rem_ff <= rem_ff - den_ff;
               end
               den_ff  <= den_ff >> 1;
               q_ff    <= q_in;
               step_ff <= step_ff + cfp_pkg::STEP_W'(1);
               if (step_ff == cfp_pkg::STEP_W'(cfp_pkg::UNIT_FRAC_BITS)) begin
                  unit_ff[idx_ff] <= neg_ff[idx_ff] ? cfp_pkg::UNIT_W'(0) - q_ext : q_ext;
                  if (idx_ff == 2'd2) begin
                     nz_ff    <= 1'b1;
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 2'd1;
                     state_ff <= N_DSET;
                  end
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign stat.done    = done_ff;
   assign stat.nonzero = nz_ff;
   assign unit_out     = unit_ff;

endmodule

// File: hw/rtl/cfp_cross.sv
// Cross product of two unit vectors, computed step by step on one shared 16x16 multiplier.
// Depends on cfp_pkg.

module cfp_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cfp_pkg::unit_vec_type a_in,
   input  cfp_pkg::unit_vec_type b_in,
   output logic                  done,
   output cfp_pkg::wide_vec_type r_out
);

   cfp_pkg::unit_vec_type a_ff;
   cfp_pkg::unit_vec_type b_ff;
   cfp_pkg::wide_vec_type r_ff;
   logic [2:0]            step_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [1:0]                 a_idx;
   logic [1:0]                 b_idx;
   logic signed [31:0]         prod;
   logic [cfp_pkg::WIDE_W-1:0] prod_w;

   always_comb begin
      unique case (step_ff)
         3'd0: begin a_idx = 2'd1; b_idx = 2'd2; end
         3'd1: begin a_idx = 2'd2; b_idx = 2'd1; end
         3'd2: begin a_idx = 2'd2; b_idx = 2'd0; end
         3'd3: begin a_idx = 2'd0; b_idx = 2'd2; end
         3'd4: begin a_idx = 2'd0; b_idx = 2'd1; end
         3'd5: begin a_idx = 2'd1; b_idx = 2'd0; end
         default: begin a_idx = 2'd0; b_idx = 2'd0; end
      endcase
   end

   assign prod   = $signed(a_ff[a_idx]) * $signed(b_ff[b_idx]);
   assign prod_w = cfp_pkg::WIDE_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               a_ff    <= a_in;
               b_ff    <= b_in;
               step_ff <= 3'd0;
               busy_ff <= 1'b1;
            end
         end else begin
            if (!step_ff[0]) begin
               r_ff[step_ff[2:1]] <= prod_w;
            end else begin
               r_ff[step_ff[2:1]] <= r_ff[step_ff[2:1]] - prod_w;
            end
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign r_out = r_ff;

endmodule

// File: hw/rtl/centerline_frame_propagation_top.sv
// Top level: point store, frame sequencer and result register of the frame propagation block.
// Depends on cfp_pkg, cfp_norm and cfp_cross.
//
//   channel | ports                          | word
//   input   | req_valid, req_stall, req_word | one centerline point, Q16.16
//   result  | rsp_valid, rsp_stall, rsp_word | one frame, Q1.14 axes and tangent
//
// A normalization runs a 31-step square root and three 15-step divides. A full frame
// costs three to five normalizations and two cross products; a point releases up to
// three frames.
// req_stall is high while a point is being worked on; a stalled result holds the
// sequencer only when it has the next frame ready. Reset clears the line state.

module centerline_frame_propagation_top #(
   parameter int INDEX_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfp_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfp_pkg::rsp_type rsp_word
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHORD, S_TAN, S_CROSS1, S_Y, S_YFB, S_CROSS2, S_X, S_EMIT
   } state_type;

   state_type               state_ff;
   logic                    issued_ff;
   logic [1:0]              fill_ff;
   logic [INDEX_BITS-1:0]   cnt_ff;
   logic [INDEX_BITS-1:0]   fidx_ff;
   logic [1:0]              rem_ff;
   logic                    eol_ff;
   logic                    short_ff;
   logic                    chord_ff;
   logic [1:0]              stat_ff;
   cfp_pkg::pos_vec_type    first_ff;
   cfp_pkg::pos_vec_type    older_ff;
   cfp_pkg::pos_vec_type    newer_ff;
   cfp_pkg::wide_vec_type   dcur_ff;
   cfp_pkg::wide_vec_type   db_ff;
   cfp_pkg::wide_vec_type   dc_ff;
   cfp_pkg::wide_vec_type   chordv_ff;
   cfp_pkg::unit_vec_type   cu_ff;
   cfp_pkg::unit_vec_type   px_ff;
   cfp_pkg::unit_vec_type   t_ff;
   cfp_pkg::unit_vec_type   y_ff;
   cfp_pkg::unit_vec_type   x_ff;
   logic                    rsp_valid_ff;
   cfp_pkg::rsp_type        rsp_word_ff;

   logic                    acc_req;
   logic                    eol_in;
   cfp_pkg::pos_vec_type    p_in;
   logic                    norm_state;
   logic                    cross_state;
   logic                    norm_go;
   logic                    cross_go;
   cfp_pkg::wide_vec_type   norm_vec;
   cfp_pkg::norm_stat_type  norm_stat;
   cfp_pkg::unit_vec_type   norm_unit;
   cfp_pkg::unit_vec_type   cross_a;
   cfp_pkg::unit_vec_type   cross_b;
   logic                    cross_done;
   cfp_pkg::wide_vec_type   cross_r;
   logic                    out_free;
   logic                    fin_now;
   logic [INDEX_BITS+15:0]  fidx_ext;

   function automatic cfp_pkg::wide_vec_type vdiff(input cfp_pkg::pos_vec_type a,
                                                  input cfp_pkg::pos_vec_type b);
      cfp_pkg::wide_vec_type r;
      for (int i = 0; i < 3; i++) begin
         r[i] = {a[i][cfp_pkg::POS_W-1], a[i]} - {b[i][cfp_pkg::POS_W-1], b[i]};
      end
      return r;
   endfunction

   assign p_in[0]  = req_word.pos_x;
   assign p_in[1]  = req_word.pos_y;
   assign p_in[2]  = req_word.pos_z;
   assign eol_in   = req_word.end_of_line;
   assign req_stall = (state_ff != S_IDLE);
   assign acc_req   = req_valid && !req_stall;

   assign norm_state  = (state_ff == S_CHORD) || (state_ff == S_TAN) || (state_ff == S_Y)
                        || (state_ff == S_YFB) || (state_ff == S_X);
   assign cross_state = (state_ff == S_CROSS1) || (state_ff == S_CROSS2);
   assign norm_go     = norm_state && !issued_ff;
   assign cross_go    = cross_state && !issued_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign fin_now     = eol_ff && (rem_ff == 2'd1);
   assign fidx_ext    = {16'd0, fidx_ff};

   always_comb begin
      unique case (state_ff)
         S_CHORD: norm_vec = chordv_ff;
         S_TAN:   norm_vec = dcur_ff;
         S_YFB: begin
            norm_vec[0] = cfp_pkg::WIDE_W'(0) - cfp_pkg::WIDE_W'($signed(t_ff[1]));
            norm_vec[1] = cfp_pkg::WIDE_W'($signed(t_ff[0]));
            norm_vec[2] = '0;
         end
         default: norm_vec = cross_r;
      endcase
      if (state_ff == S_CROSS1) begin
         cross_a = t_ff;
         cross_b = chord_ff ? cu_ff : px_ff;
      end else begin
         cross_a = y_ff;
         cross_b = t_ff;
      end
   end

   cfp_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_go),
      .vec_in   (norm_vec),
      .stat     (norm_stat),
      .unit_out (norm_unit)
   );

   cfp_cross u_cross (
      .clock (clock),
      .reset (reset),
      .start (cross_go),
      .a_in  (cross_a),
      .b_in  (cross_b),
      .done  (cross_done),
      .r_out (cross_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         fill_ff      <= 2'd0;
         cnt_ff       <= '0;
         px_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (norm_go || cross_go) begin
            issued_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (acc_req) begin
                  eol_ff <= eol_in;
                  unique case (fill_ff)
                     2'd0: begin
                        first_ff <= p_in;
                        newer_ff <= p_in;
                        dcur_ff  <= '0;
                        rem_ff   <= eol_in ? 2'd1 : 2'd0;
                        fidx_ff  <= cnt_ff;
                        short_ff <= 1'b1;
                        chord_ff <= 1'b0;
                        state_ff <= eol_in ? S_TAN : S_IDLE;
                     end
                     2'd1: begin
                        older_ff <= newer_ff;
                        newer_ff <= p_in;
                        dcur_ff  <= vdiff(p_in, newer_ff);
                        rem_ff   <= eol_in ? 2'd2 : 2'd0;
                        fidx_ff  <= cnt_ff - INDEX_BITS'(1);
                        short_ff <= 1'b1;
                        chord_ff <= 1'b0;
                        state_ff <= eol_in ? S_TAN : S_IDLE;
                     end
                     2'd2: begin
                        older_ff  <= newer_ff;
                        newer_ff  <= p_in;
                        chordv_ff <= vdiff(p_in, first_ff);
                        dcur_ff   <= vdiff(newer_ff, first_ff);
                        db_ff     <= vdiff(p_in, older_ff);
                        dc_ff     <= vdiff(p_in, newer_ff);
                        rem_ff    <= eol_in ? 2'd3 : 2'd2;
                        fidx_ff   <= cnt_ff - INDEX_BITS'(2);
                        short_ff  <= 1'b0;
                        chord_ff  <= 1'b1;
                        state_ff  <= S_CHORD;
                     end
                     default: begin
                        older_ff <= newer_ff;
                        newer_ff <= p_in;
                        dcur_ff  <= vdiff(p_in, older_ff);
                        db_ff    <= vdiff(p_in, newer_ff);
                        rem_ff   <= eol_in ? 2'd2 : 2'd1;
                        fidx_ff  <= cnt_ff - INDEX_BITS'(1);
                        short_ff <= 1'b0;
                        chord_ff <= 1'b0;
                        state_ff <= S_TAN;
                     end
                  endcase
                  if (eol_in) begin
                     cnt_ff  <= '0;
                     fill_ff <= 2'd0;
                  end else begin
                     cnt_ff <= cnt_ff + INDEX_BITS'(1);
                     if (fill_ff != 2'd3) begin
                        fill_ff <= fill_ff + 2'd1;
                     end
                  end
               end
            end
            S_CHORD: begin
               if (issued_ff && norm_stat.done) begin
                  issued_ff <= 1'b0;
                  cu_ff     <= norm_unit;
                  state_ff  <= S_TAN;
               end
            end
            S_TAN: begin
               if (issued_ff && norm_stat.done) begin
                  issued_ff <= 1'b0;
                  t_ff      <= norm_unit;
                  priority if (short_ff) begin
                     x_ff     <= '0;
                     y_ff     <= '0;
                     stat_ff  <= cfp_pkg::STAT_SHORT;
                     state_ff <= S_EMIT;
                  end else if (!norm_stat.nonzero) begin
                     x_ff     <= '0;
                     y_ff     <= '0;
                     stat_ff  <= cfp_pkg::STAT_ZERO;
                     state_ff <= S_EMIT;
                  end else begin
                     stat_ff  <= cfp_pkg::STAT_OK;
                     state_ff <= S_CROSS1;
                  end
               end
            end
            S_CROSS1: begin
               if (issued_ff && cross_done) begin
                  issued_ff <= 1'b0;
                  state_ff  <= S_Y;
               end
            end
            S_Y: begin
               if (issued_ff && norm_stat.done) begin
                  issued_ff <= 1'b0;
                  if (norm_stat.nonzero) begin
                     y_ff     <= norm_unit;
                     state_ff <= S_CROSS2;
                  end else begin
                     stat_ff  <= cfp_pkg::STAT_FALLBACK;
                     state_ff <= S_YFB;
                  end
               end
            end
            S_YFB: begin
               if (issued_ff && norm_stat.done) begin
                  issued_ff <= 1'b0;
                  if (norm_stat.nonzero) begin
                     y_ff <= norm_unit;
                  end else begin
                     y_ff[0] <= '0;
                     y_ff[1] <= cfp_pkg::UNIT_ONE;
                     y_ff[2] <= '0;
                  end
                  state_ff <= S_CROSS2;
               end
            end
            S_CROSS2: begin
               if (issued_ff && cross_done) begin
                  issued_ff <= 1'b0;
                  state_ff  <= S_X;
               end
            end
            S_X: begin
               if (issued_ff && norm_stat.done) begin
                  issued_ff <= 1'b0;
                  x_ff      <= norm_unit;
                  px_ff     <= norm_unit;
                  state_ff  <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_word_ff.frame_index  <= fidx_ext[15:0];
                  rsp_word_ff.axis_x_0     <= x_ff[0];
                  rsp_word_ff.axis_x_1     <= x_ff[1];
                  rsp_word_ff.axis_x_2     <= x_ff[2];
                  rsp_word_ff.axis_y_0     <= y_ff[0];
                  rsp_word_ff.axis_y_1     <= y_ff[1];
                  rsp_word_ff.axis_y_2     <= y_ff[2];
                  rsp_word_ff.tan_0        <= t_ff[0];
                  rsp_word_ff.tan_1        <= t_ff[1];
                  rsp_word_ff.tan_2        <= t_ff[2];
                  rsp_word_ff.status       <= stat_ff;
                  rsp_word_ff.final_frame  <= fin_now;
                  rem_ff                   <= rem_ff - 2'd1;
                  fidx_ff                  <= fidx_ff + INDEX_BITS'(1);
                  priority if (rem_ff == 2'd1) begin
                     if (eol_ff) begin
                        px_ff <= '0;
                     end
                     state_ff <= S_IDLE;
                  end else if (short_ff) begin
                     state_ff <= S_EMIT;
                  end else begin
                     dcur_ff  <= db_ff;
                     db_ff    <= dc_ff;
                     chord_ff <= 1'b0;
                     state_ff <= S_TAN;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_zero_tangent_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == cfp_pkg::STAT_ZERO) |->
         (rsp_word.axis_x_0 == 16'sd0) && (rsp_word.axis_y_1 == 16'sd0)
         && (rsp_word.tan_0 == 16'sd0) && (rsp_word.tan_1 == 16'sd0)
         && (rsp_word.tan_2 == 16'sd0))
      else $error("zero-length tangent frame carries nonzero vectors");

   a_short_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == cfp_pkg::STAT_SHORT) |->
         (rsp_word.axis_x_0 == 16'sd0) && (rsp_word.axis_x_1 == 16'sd0)
         && (rsp_word.axis_y_0 == 16'sd0) && (rsp_word.axis_y_2 == 16'sd0))
      else $error("short-line frame carries nonzero axes");

   a_ok_tangent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == cfp_pkg::STAT_OK) |->
         (rsp_word.tan_0 != 16'sd0) || (rsp_word.tan_1 != 16'sd0)
         || (rsp_word.tan_2 != 16'sd0))
      else $error("regular frame with zero tangent");

   a_one_unit_busy: assert property (@(posedge clock) disable iff (reset)
      !(norm_go && cross_go))
      else $error("normalizer and cross unit started together");

endmodule

// File: dv/centerline_frame_propagation_top_test.sv
// Self-checking bench for centerline_frame_propagation_top: random and directed point lines,
// frames predicted in-bench and checked in order through a small scoreboard class.
// Depends on cfp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module centerline_frame_propagation_top_test;

   class frame_scoreboard;
      cfp_pkg::rsp_type pending_frames[$];
      int      error_count;
      logic signed [63:0] first_pt[3], older_pt[3], newer_pt[3], last_x[3];
      logic [15:0] point_idx;
      int          fill;

      function void clear_line();
         for (int i = 0; i < 3; i++) begin
            first_pt[i] = 0; older_pt[i] = 0; newer_pt[i] = 0; last_x[i] = 0;
         end
         point_idx = 0;
         fill = 0;
      endfunction

      function logic [63:0] root64(logic [63:0] v);
         logic [63:0] res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function bit unit_of(input logic signed [63:0] v[3], output logic signed [63:0] u[3]);
         logic [63:0] m[3], mx, sum, len, q;
         bit neg[3];
         mx = 0;
         for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
         end
         if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return 0;
         end
         while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
         end
         while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
         end
         sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         len = root64(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << cfp_pkg::UNIT_FRAC_BITS) + (len >> 1)) / len;
            u[i] = neg[i] ? -$signed(q) : $signed(q);
         end
         return 1;
      endfunction

      function void cross_of(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                             output logic signed [63:0] r[3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function void push_frame(logic [15:0] idx, logic signed [63:0] x[3],
                               logic signed [63:0] y[3], logic signed [63:0] t[3],
                               logic [1:0] stat, bit fin);
         cfp_pkg::rsp_type f;
         f.frame_index = idx;
         f.axis_x_0 = x[0][15:0]; f.axis_x_1 = x[1][15:0]; f.axis_x_2 = x[2][15:0];
         f.axis_y_0 = y[0][15:0]; f.axis_y_1 = y[1][15:0]; f.axis_y_2 = y[2][15:0];
         f.tan_0 = t[0][15:0]; f.tan_1 = t[1][15:0]; f.tan_2 = t[2][15:0];
         f.status = stat;
         f.final_frame = fin;
         pending_frames = {pending_frames, f};
      endfunction

      function void short_frame(logic [15:0] idx, logic signed [63:0] d[3], bit fin);
         logic signed [63:0] t[3], z[3];
         for (int i = 0; i < 3; i++) z[i] = 0;
         void'(unit_of(d, t));
         push_frame(idx, z, z, t, cfp_pkg::STAT_SHORT, fin);
      endfunction

      function void full_frame(logic [15:0] idx, logic signed [63:0] d[3],
                               logic signed [63:0] ref_v[3], bit fin);
         logic signed [63:0] t[3], y[3], x[3], w[3], z[3];
         logic [1:0] stat;
         stat = cfp_pkg::STAT_OK;
         for (int i = 0; i < 3; i++) z[i] = 0;
         if (!unit_of(d, t)) begin
            push_frame(idx, z, z, z, cfp_pkg::STAT_ZERO, fin);
            return;
         end
         cross_of(t, ref_v, w);
         if (!unit_of(w, y)) begin
            stat = cfp_pkg::STAT_FALLBACK;
            w[0] = -t[1]; w[1] = t[0]; w[2] = 0;
            if (!unit_of(w, y)) begin
               y[0] = 0; y[1] = 64'sd1 << cfp_pkg::UNIT_FRAC_BITS; y[2] = 0;
            end
         end
         cross_of(y, t, w);
         void'(unit_of(w, x));
         for (int i = 0; i < 3; i++) last_x[i] = x[i];
         push_frame(idx, x, y, t, stat, fin);
      endfunction

      function void note_point(cfp_pkg::req_type r);
         logic signed [63:0] p[3], d[3], c[3], cu[3], z[3];
         logic [15:0] idx;
         idx = point_idx;
         p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
         for (int i = 0; i < 3; i++) z[i] = 0;
         if (fill == 0) begin
            for (int i = 0; i < 3; i++) begin
               first_pt[i] = p[i]; newer_pt[i] = p[i];
            end
            if (r.end_of_line) short_frame(idx, z, 1);
         end else if (fill == 1) begin
            for (int i = 0; i < 3; i++) begin
               older_pt[i] = newer_pt[i]; newer_pt[i] = p[i];
            end
            if (r.end_of_line) begin
               for (int i = 0; i < 3; i++) d[i] = p[i] - older_pt[i];
               short_frame(idx - 16'd1, d, 0);
               short_frame(idx, d, 1);
            end
         end else begin
            if (fill == 2) begin
               for (int i = 0; i < 3; i++) begin
                  d[i] = newer_pt[i] - first_pt[i];
                  c[i] = p[i] - first_pt[i];
               end
               void'(unit_of(c, cu));
               full_frame(idx - 16'd2, d, cu, 0);
            end
            for (int i = 0; i < 3; i++) d[i] = p[i] - older_pt[i];
            full_frame(idx - 16'd1, d, last_x, 0);
            if (r.end_of_line) begin
               for (int i = 0; i < 3; i++) d[i] = p[i] - newer_pt[i];
               full_frame(idx, d, last_x, 1);
            end
            for (int i = 0; i < 3; i++) begin
               older_pt[i] = newer_pt[i]; newer_pt[i] = p[i];
            end
         end
         if (r.end_of_line) begin
            clear_line();
         end else begin
            point_idx = point_idx + 16'd1;
            if (fill < 3) fill++;
         end
      endfunction

      function void check_frame(cfp_pkg::rsp_type got);
         cfp_pkg::rsp_type want;
         if (pending_frames.size() == 0) begin
            $display("%0t unexpected frame %h", $realtime, got);
            error_count++;
            return;
         end
         want = pending_frames.pop_front();
         if (got !== want) begin
            $display("%0t frame mismatch expected %h actual %h", $realtime, want, got);
            error_count++;
         end
      endfunction
   endclass

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   cfp_pkg::req_type req_word;
   cfp_pkg::rsp_type rsp_word;
   frame_scoreboard frames;
   int      cycle_count;
   bit      hold_rx;

   centerline_frame_propagation_top dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   // result side: random stall, plus a long hold-off on request
   initial begin
      int g;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            rsp_stall <= 1'b1;
            repeat (6000) @(posedge clock);
            hold_rx = 0;
            rsp_stall <= 1'b0;
         end else begin
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
               rsp_stall <= 1'b1;
               repeat (g) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) frames.check_frame(rsp_word);
   end

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit eol);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{pos_x: x, pos_y: y, pos_z: z, end_of_line: eol};
      do @(posedge clock); while (req_stall);
      frames.note_point(req_word);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frames.pending_frames.size() != 0) @(posedge clock);
   endtask

   function logic signed [31:0] rnd_coord(int span);
      if (span == 0) return $signed($urandom());
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   initial begin
      int n, len, span;
      logic signed [31:0] cx, cy, cz;
      frames = new();
      frames.clear_line();
      hold_rx = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-point line, two-point lines, degenerate and extreme points
      send_point(32'sd5, -32'sd7, 32'sd9, 1);
      send_point(0, 0, 0, 0);
      send_point(0, 0, 0, 1);
      send_point(32'sh7FFFFFFF, 32'sh80000000, 0, 0);
      send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
      // collinear line: parallel fallback
      for (int i = 0; i < 4; i++) send_point(i * 65536, 0, 0, i == 3);
      // repeated points: zero tangent
      for (int i = 0; i < 4; i++) send_point(100, 100, 100, i == 3);
      // straight along z: fallback to (0,1,0)
      for (int i = 0; i < 3; i++) send_point(0, 0, i * 1000, i == 2);
      // extremes within one line
      send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
      send_point(-1, 32'sh7FFFFFFF, 0, 0);
      send_point(32'sh80000000, 1, -1, 1);
      wait_drained();

      n = 0;
      while (n < 140) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         span = ($urandom_range(0, 4) == 0) ? 0 : (1 << $urandom_range(4, 30));
         cx = rnd_coord(span); cy = rnd_coord(span); cz = rnd_coord(span);
         if (n >= 40 && n < 52 && !hold_rx) hold_rx = 1;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               cx = rnd_coord(span); cy = rnd_coord(span); cz = rnd_coord(span);
            end else begin
               cx = cx + (rnd_coord(1 << 18) >>> $urandom_range(0, 12));
               cy = cy + (rnd_coord(1 << 18) >>> $urandom_range(0, 12));
               cz = cz + (rnd_coord(1 << 18) >>> $urandom_range(0, 12));
            end
            send_point(cx, cy, cz, i == len - 1);
            n++;
         end
         if (n > 100 && n < 115) wait_drained();
      end

      wait_drained();
      repeat (3000) @(posedge clock);
      if (frames.error_count == 0 && frames.pending_frames.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_norm.sv
hw/rtl/cfp_cross.sv
hw/rtl/centerline_frame_propagation_top.sv
dv/centerline_frame_propagation_top_test.sv
